// File: rtl/bcfp_pkg.sv
// Shared types, byte codes and a helper function for the braced command frame parser.
package bcfp_pkg;

  localparam int INT_W        = 16;
  localparam int FRAC_W       = 17;
  localparam int RECIP_SHIFT  = 17;

  localparam logic [7:0] OPEN_BYTE   = 8'h7B;
  localparam logic [7:0] CLOSE_BYTE  = 8'h7D;
  localparam logic [7:0] REQ_BYTE    = 8'h50;
  localparam logic [7:0] SEL_LOW     = 8'h30;
  localparam logic [7:0] SEL_HIGH    = 8'h35;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [2:0]        MAX_FRAC_DIGITS = 3'd5;
  localparam logic [INT_W-1:0]  INT_CAP         = 16'hFFFF;
  localparam logic [FRAC_W-1:0] FRAC_SCALE      = 17'd100000;

  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } num_phase_t;

  // Frame summary handed from the parser to the value pipeline.
  // frac_digits holds the fraction scaled to five decimal places.
  typedef struct packed {
    logic              kind;
    logic [2:0]        target;
    logic              overflowed;
    logic              sign;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_digits;
  } bcfp_item_t;

  // Weight of the next fraction digit, given how many are already in.
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] n);
    logic [FRAC_W-1:0] w;
    case (n)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      3'd4:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/bcfp_if.sv
// Valid/ready stream interfaces for received bytes and parser results.
interface bcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bcfp_result_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         target;
  logic signed [31:0] value;
  logic               overflowed;

  modport source (output valid, output kind, output target, output value, output overflowed,
                  input ready);
  modport sink   (input valid, input kind, input target, input value, input overflowed,
                  output ready);
endinterface

// File: rtl/bcfp_parser.sv
// Byte-level frame tracker and streaming decimal number scanner.
module bcfp_parser #(
  parameter int FRAME_BYTES  = 50,
  parameter int NUMBER_CHARS = 19
) (
  input  logic                clk,
  input  logic                rst,
  bcfp_byte_if.sink           rx,
  input  logic                room,
  output logic                item_valid,
  output bcfp_pkg::bcfp_item_t item
);
  import bcfp_pkg::*;

  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int NCW = $clog2(NUMBER_CHARS + 1);

  logic              in_frame, in_frame_next;
  logic [CW-1:0]     stored_count, stored_count_next;
  logic [7:0]        selector_byte, selector_byte_next;
  logic [7:0]        request_byte, request_byte_next;
  logic [7:0]        pending_byte, pending_byte_next;
  logic              number_sign, number_sign_next;
  logic [INT_W-1:0]  integer_part, integer_part_next;
  logic [FRAC_W-1:0] frac_digits, frac_digits_next;
  logic [2:0]        frac_count, frac_count_next;
  num_phase_t        number_phase, number_phase_next;
  logic [NCW-1:0]    number_chars, number_chars_next;
  logic              overflow_flag, overflow_flag_next;

  logic        take;
  logic [7:0]  c;
  logic [7:0]  p;
  logic [3:0]  p_digit;
  logic        p_is_digit;
  logic [19:0] int_acc;
  logic [20:0] frac_add;

  assign rx.ready = room;
  assign take     = rx.valid && room;
  assign c        = rx.rx_byte;
  assign p        = pending_byte;
  assign p_digit  = p[3:0];
  assign p_is_digit = (p inside {[DIGIT_0:DIGIT_9]});
  assign int_acc  = 20'(integer_part) * 20'd10 + 20'(p_digit);
  assign frac_add = 21'(p_digit) * 21'(frac_weight(frac_count));

  always_comb begin
    in_frame_next      = in_frame;
    stored_count_next  = stored_count;
    selector_byte_next = selector_byte;
    request_byte_next  = request_byte;
    pending_byte_next  = pending_byte;
    number_sign_next   = number_sign;
    integer_part_next  = integer_part;
    frac_digits_next   = frac_digits;
    frac_count_next    = frac_count;
    number_phase_next  = number_phase;
    number_chars_next  = number_chars;
    overflow_flag_next = overflow_flag;

    item_valid       = 1'b0;
    item.kind        = KIND_UPDATE;
    item.target      = 3'(selector_byte - SEL_LOW);
    item.overflowed  = overflow_flag;
    item.sign        = number_sign;
    item.int_part    = integer_part;
    item.frac_digits = frac_digits;

    if (take) begin
      if (c == CLOSE_BYTE) begin
        if (in_frame) begin
          if (request_byte == REQ_BYTE) begin
            item_valid       = 1'b1;
            item.kind        = KIND_REQUEST;
            item.target      = 3'd0;
            item.sign        = 1'b0;
            item.int_part    = '0;
            item.frac_digits = '0;
          end else if (selector_byte inside {[SEL_LOW:SEL_HIGH]}) begin
            item_valid = 1'b1;
          end
        end
        in_frame_next      = 1'b0;
        stored_count_next  = '0;
        selector_byte_next = '0;
        request_byte_next  = '0;
        pending_byte_next  = '0;
        number_sign_next   = 1'b0;
        integer_part_next  = '0;
        frac_digits_next   = '0;
        frac_count_next    = '0;
        number_phase_next  = PH_BEFORE;
        number_chars_next  = '0;
        overflow_flag_next = 1'b0;
      end else if (in_frame || c == OPEN_BYTE) begin
        in_frame_next = 1'b1;
        if (stored_count < CW'(FRAME_BYTES)) begin
          if (stored_count == CW'(1)) begin
            selector_byte_next = c;
          end
          if (stored_count == CW'(3)) begin
            request_byte_next = c;
          end
          // held-back byte enters the number once a later byte arrives
          if (stored_count >= CW'(4) && number_chars < NCW'(NUMBER_CHARS)) begin
            number_chars_next = number_chars + NCW'(1);
            case (number_phase)
              PH_BEFORE: begin
                if (p == CHAR_SPACE || (p inside {[CHAR_TAB:CHAR_CR]})) begin
                  number_phase_next = PH_BEFORE;
                end else if (p == CHAR_PLUS) begin
                  number_phase_next = PH_INT;
                end else if (p == CHAR_MINUS) begin
                  number_sign_next  = 1'b1;
                  number_phase_next = PH_INT;
                end else if (p_is_digit) begin
                  integer_part_next = INT_W'(p_digit);
                  number_phase_next = PH_INT;
                end else if (p == CHAR_POINT) begin
                  number_phase_next = PH_FRAC;
                end else begin
                  number_phase_next = PH_DONE;
                end
              end
              PH_INT: begin
                if (p_is_digit) begin
                  integer_part_next = (int_acc > 20'(INT_CAP)) ? INT_CAP : int_acc[INT_W-1:0];
                end else if (p == CHAR_POINT) begin
                  number_phase_next = PH_FRAC;
                end else begin
                  number_phase_next = PH_DONE;
                end
              end
              PH_FRAC: begin
                if (p_is_digit) begin
                  if (frac_count < MAX_FRAC_DIGITS) begin
                    frac_digits_next = frac_digits + FRAC_W'(frac_add);
                    frac_count_next  = frac_count + 3'd1;
                  end
                end else begin
                  number_phase_next = PH_DONE;
                end
              end
              default: begin
                number_phase_next = number_phase;
              end
            endcase
          end
          pending_byte_next = c;
          stored_count_next = stored_count + CW'(1);
        end else begin
          overflow_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      stored_count  <= '0;
      selector_byte <= '0;
      request_byte  <= '0;
      pending_byte  <= '0;
      number_sign   <= 1'b0;
      integer_part  <= '0;
      frac_digits   <= '0;
      frac_count    <= '0;
      number_phase  <= PH_BEFORE;
      number_chars  <= '0;
      overflow_flag <= 1'b0;
    end else begin
      in_frame      <= in_frame_next;
      stored_count  <= stored_count_next;
      selector_byte <= selector_byte_next;
      request_byte  <= request_byte_next;
      pending_byte  <= pending_byte_next;
      number_sign   <= number_sign_next;
      integer_part  <= integer_part_next;
      frac_digits   <= frac_digits_next;
      frac_count    <= frac_count_next;
      number_phase  <= number_phase_next;
      number_chars  <= number_chars_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule

// File: rtl/bcfp_value.sv
// Fixed-point conversion pipeline: fraction scaling, saturation and result register.
module bcfp_value #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  bcfp_pkg::bcfp_item_t in_item,
  output logic                 in_ready,
  bcfp_result_if.source        tx
);
  import bcfp_pkg::*;

  // fraction = floor(frac_digits * 2^FRAC_BITS / 100000), via reciprocal plus one-step fix
  localparam int MW   = FRAC_BITS + 1;
  localparam int PW   = FRAC_W + MW;
  localparam int CKW  = MW + FRAC_W;
  localparam int MAGW = INT_W + FRAC_BITS;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << (FRAC_BITS + RECIP_SHIFT)) + 64'(FRAC_SCALE) - 64'd1) / 64'(FRAC_SCALE));

  logic en1, en2, en3, en4, en5;

  logic       v1;
  bcfp_item_t it1;

  logic          v2;
  bcfp_item_t    it2;
  logic [PW-1:0] prod2;

  logic           v3;
  bcfp_item_t     it3;
  logic [MW-1:0]  qe3;
  logic [CKW-1:0] chk3;

  logic            v4;
  logic            kind4;
  logic [2:0]      target4;
  logic            ovf4;
  logic            sign4;
  logic [MAGW-1:0] mag4;

  logic               v5;
  logic               kind5;
  logic [2:0]         target5;
  logic               ovf5;
  logic signed [31:0] value5;

  logic [CKW-1:0]       num3;
  logic [FRAC_BITS-1:0] q3;
  logic [63:0]          mag64;
  logic [31:0]          sat4;

  assign en5 = !v5 || tx.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign num3 = CKW'({it3.frac_digits, {FRAC_BITS{1'b0}}});
  assign q3   = (chk3 > num3) ? FRAC_BITS'(qe3 - MW'(1)) : FRAC_BITS'(qe3);

  assign mag64 = 64'(mag4);
  always_comb begin
    if (sign4) begin
      sat4 = (mag64 >= 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - mag64[31:0]);
    end else begin
      sat4 = (mag64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1 <= in_item;
    end
    if (en2) begin
      it2   <= it1;
      prod2 <= PW'(it1.frac_digits) * PW'(RECIP);
    end
    if (en3) begin
      it3  <= it2;
      qe3  <= prod2[PW-1:RECIP_SHIFT];
      chk3 <= CKW'(prod2[PW-1:RECIP_SHIFT]) * CKW'(FRAC_SCALE);
    end
    if (en4) begin
      kind4   <= it3.kind;
      target4 <= it3.target;
      ovf4    <= it3.overflowed;
      sign4   <= it3.sign;
      mag4    <= {it3.int_part, q3};
    end
    if (en5) begin
      kind5   <= kind4;
      target5 <= target4;
      ovf5    <= ovf4;
      value5  <= sat4;
    end
  end

  assign tx.valid      = v5;
  assign tx.kind       = kind5;
  assign tx.target     = target5;
  assign tx.value      = value5;
  assign tx.overflowed = ovf5;

endmodule

// File: rtl/braced_command_frame_parser_unit.sv
// Top level of the braced command frame parser.
//
// rx carries one received byte per beat; cmd carries one command per beat
// (kind, target, value in signed fixed point with FRAC_BITS fraction bits,
// overflowed). Both are valid/ready; a beat moves when both are high.
// A byte is taken every cycle while the value pipeline has room in its
// first stage; bytes that do not close a frame never occupy the pipeline.
// A closing brace that yields a command enters a five-register pipeline
// (frame summary, reciprocal multiply, correction multiply, fraction fix,
// saturation into the output register) before the command shows on cmd.
// Sustained rate is one byte per cycle while cmd is not stalled.
// When cmd is stalled, commands queue in the pipeline stages, and rx ready
// drops only once the first stage holds a command that cannot move on.
// Synchronous reset clears the frame state and all pipeline valid flags;
// the block is ready for bytes in the first cycle after reset.
module braced_command_frame_parser_unit #(
  parameter int FRAME_BYTES  = 50,
  parameter int NUMBER_CHARS = 19,
  parameter int FRAC_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst,
  bcfp_byte_if.sink     rx,
  bcfp_result_if.source cmd
);
  import bcfp_pkg::*;

  logic       room;
  logic       item_valid;
  bcfp_item_t item;

  bcfp_parser #(
    .FRAME_BYTES  (FRAME_BYTES),
    .NUMBER_CHARS (NUMBER_CHARS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .room       (room),
    .item_valid (item_valid),
    .item       (item)
  );

  bcfp_value #(
    .FRAC_BITS (FRAC_BITS)
  ) u_value (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_item  (item),
    .in_ready (room),
    .tx       (cmd)
  );

endmodule
